// File: src/lsmc_pkg.sv
// ----------------------------------------------------------------------------
// lsmc_pkg: shared types and constants of the light servo mode controller
// Event codes, message codes, register indexes, reset values and the
// servo scaling function used by the update core.
// ----------------------------------------------------------------------------
package lsmc_pkg;

  // Field widths
  localparam int unsigned EvW      = 3;
  localparam int unsigned DataW    = 10;
  localparam int unsigned ModeW    = 2;
  localparam int unsigned DigitW   = 2;
  localparam int unsigned ServoW   = 16;
  localparam int unsigned MsgW     = 3;
  localparam int unsigned TickW    = 8;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 40;

  // Event codes
  typedef enum logic [EvW-1:0] {
    EvPower  = 3'd0,
    EvModeBtn = 3'd1,
    EvChar   = 3'd2,
    EvTick   = 3'd3,
    EvSample = 3'd4
  } event_e;

  // Message codes
  localparam logic [MsgW-1:0] MsgNone    = 3'd0;
  localparam logic [MsgW-1:0] MsgModeSet = 3'd1;  // plus the new mode
  localparam logic [MsgW-1:0] MsgInvalid = 3'd4;
  localparam logic [MsgW-1:0] MsgReport  = 3'd5;

  // Operating modes
  localparam logic [ModeW-1:0] ModeData   = 2'd0;
  localparam logic [ModeW-1:0] ModeAuto   = 2'd1;
  localparam logic [ModeW-1:0] ModeManual = 2'd2;

  // Display code for blank with standby point
  localparam logic [DigitW-1:0] DigitBlank = 2'd3;

  // Characters accepted as mode commands
  localparam logic [7:0] CharZero = 8'h30;
  localparam logic [7:0] CharTwo  = 8'h32;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CfgReportInterval = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgServoBase      = 2'd1;

  // Reset values
  localparam logic [TickW-1:0]  ReportIntervalRst = 8'd20;
  localparam logic [ServoW-1:0] ServoBaseRst      = 16'd1000;
  localparam logic [ServoW-1:0] ServoValueRst     = 16'd1000;

  typedef struct packed {
    logic [EvW-1:0]   mode;
    logic [DataW-1:0] event_data;
  } item_t;

  typedef struct packed {
    logic [DataW-1:0]  report_value;
    logic [MsgW-1:0]   message;
    logic [ServoW-1:0] servo_compare;
    logic              channel_select;
    logic [DigitW-1:0] digit_shown;
    logic [ModeW-1:0]  current_mode;
    logic              powered;
  } result_t;

  // Light contribution: 15*s + 5*(s>>3), s = sample >> 2 (fits in 12 bits)
  function automatic logic [11:0] light_contrib(input logic [DataW-1:0] sample);
    logic [7:0]  s;
    logic [4:0]  s8;
    logic [11:0] sum;
    s   = sample[DataW-1:2];
    s8  = s[7:3];
    sum = {s, 4'b0000} - {4'b0000, s} + {5'b00000, s8, 2'b00} + {7'b0000000, s8};
    return sum;
  endfunction

endpackage

// File: src/lsmc_in_reg.sv
// ----------------------------------------------------------------------------
// lsmc_in_reg: input register stage
// Captures one event transfer and holds it until the update core takes it.
// ----------------------------------------------------------------------------
module lsmc_in_reg (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  logic            take_i,
  input  lsmc_pkg::item_t item_i,
  output logic            valid_o,
  output lsmc_pkg::item_t item_o
);

  logic            valid_d, valid_q;
  lsmc_pkg::item_t item_q;

  // Fill on transfer, drain when the core takes the item
  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Hold payload until the next transfer
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// File: src/lsmc_core.sv
// ----------------------------------------------------------------------------
// lsmc_core: controller state and update logic
// Holds power, mode, tick count, servo compare and the two configuration
// registers; computes the result of the current event in one pass.
// ----------------------------------------------------------------------------
module lsmc_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            fire_i,
  input  lsmc_pkg::item_t                 item_i,
  input  logic                            cfg_we_i,
  input  logic [lsmc_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [lsmc_pkg::CfgDataW-1:0]   cfg_data_i,
  output lsmc_pkg::result_t               result_o
);

  logic                           power_d, power_q;
  logic [lsmc_pkg::ModeW-1:0]     mode_d, mode_q;
  logic [lsmc_pkg::TickW-1:0]     tick_d, tick_q;
  logic [lsmc_pkg::ServoW-1:0]    servo_d, servo_q;
  logic [lsmc_pkg::TickW-1:0]     interval_q;
  logic [lsmc_pkg::ServoW-1:0]    base_q;
  logic [lsmc_pkg::MsgW-1:0]      msg;
  logic [lsmc_pkg::DataW-1:0]     rep;
  logic [7:0]                     chr;
  logic [lsmc_pkg::ModeW-1:0]     mode_next_btn;

  assign chr           = item_i.event_data[7:0];
  assign mode_next_btn = (mode_q >= lsmc_pkg::ModeManual) ? lsmc_pkg::ModeData
                                                          : mode_q + 2'd1;

  // Apply one event to the state
  always_comb begin
    power_d = power_q;
    mode_d  = mode_q;
    tick_d  = tick_q;
    servo_d = servo_q;
    msg     = lsmc_pkg::MsgNone;
    rep     = '0;
    case (item_i.mode)
      lsmc_pkg::EvPower: begin
        power_d = ~power_q;
      end
      lsmc_pkg::EvModeBtn: begin
        if (power_q) begin
          mode_d = mode_next_btn;
          msg    = lsmc_pkg::MsgModeSet + {1'b0, mode_next_btn};
        end
      end
      lsmc_pkg::EvChar: begin
        if (power_q) begin
          if (chr >= lsmc_pkg::CharZero && chr <= lsmc_pkg::CharTwo) begin
            mode_d = chr[1:0];
            msg    = lsmc_pkg::MsgModeSet + {1'b0, chr[1:0]};
          end else begin
            msg = lsmc_pkg::MsgInvalid;
          end
        end
      end
      lsmc_pkg::EvTick: begin
        tick_d = tick_q + 8'd1;
      end
      lsmc_pkg::EvSample: begin
        if (power_q) begin
          if (mode_q == lsmc_pkg::ModeData) begin
            if (tick_q > interval_q) begin
              msg    = lsmc_pkg::MsgReport;
              rep    = item_i.event_data;
              tick_d = '0;
            end
          end else begin
            servo_d = base_q + {4'b0000, lsmc_pkg::light_contrib(item_i.event_data)};
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Result shows the state after the event
  always_comb begin
    result_o.powered        = power_d;
    result_o.current_mode   = mode_d;
    result_o.digit_shown    = power_d ? mode_d : lsmc_pkg::DigitBlank;
    result_o.channel_select = (mode_d == lsmc_pkg::ModeManual);
    result_o.servo_compare  = servo_d;
    result_o.message        = msg;
    result_o.report_value   = rep;
  end

  // Advance state on each event taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      power_q <= 1'b0;
      mode_q  <= lsmc_pkg::ModeData;
      tick_q  <= '0;
      servo_q <= lsmc_pkg::ServoValueRst;
    end else if (fire_i) begin
      power_q <= power_d;
      mode_q  <= mode_d;
      tick_q  <= tick_d;
      servo_q <= servo_d;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= lsmc_pkg::ReportIntervalRst;
      base_q     <= lsmc_pkg::ServoBaseRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        lsmc_pkg::CfgReportInterval: interval_q <= cfg_data_i[lsmc_pkg::TickW-1:0];
        lsmc_pkg::CfgServoBase:      base_q     <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

endmodule

// File: src/lsmc_out_reg.sv
// ----------------------------------------------------------------------------
// lsmc_out_reg: result register
// Holds one finished result until the downstream side takes it.
// ----------------------------------------------------------------------------
module lsmc_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  logic              ready_i,
  input  lsmc_pkg::result_t result_i,
  output logic              valid_o,
  output lsmc_pkg::result_t result_o
);

  logic              valid_d, valid_q;
  lsmc_pkg::result_t result_q;

  // Fill on load, drop after a completed transfer
  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

// File: src/light_servo_mode_controller.sv
// ----------------------------------------------------------------------------
// light_servo_mode_controller: power, mode and servo control from events
//
//   channel  | direction | handshake             | payload
//   s_axis   | in        | tvalid / tready       | tuser: mode, tdata: event_data
//   m_axis   | out       | tvalid / tready       | tdata: full status result
//   cfg      | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One event per cycle unless m_axis stalls: input register, one update
// pass, result register.
// Reset clears power, mode and tick count, loads servo compare and servo
// base with 1000 and the report interval with 20. No clearing pass.
// A stalled m_axis holds its result; the input register still takes one
// more event, then s_axis_tready drops until the result is taken.
// ----------------------------------------------------------------------------
module light_servo_mode_controller (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [lsmc_pkg::InDataW-1:0]   s_axis_tdata,  // [9:0] event_data
  input  logic [lsmc_pkg::EvW-1:0]       s_axis_tuser,  // [2:0] mode
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [0] powered, [2:1] current_mode, [4:3] digit_shown, [5] channel_select,
  // [21:6] servo_compare, [24:22] message, [34:25] report_value
  output logic [lsmc_pkg::OutDataW-1:0]  m_axis_tdata,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [lsmc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [lsmc_pkg::CfgDataW-1:0]  cfg_data_i
);

  logic              in_accept;
  logic              in_valid;
  logic              out_free;
  logic              take;
  lsmc_pkg::item_t   item_in;
  lsmc_pkg::item_t   item_q;
  lsmc_pkg::result_t result_d;
  lsmc_pkg::result_t result_q;

  // Handshake and stage advance; hold both readies low during reset
  assign out_free      = ~m_axis_tvalid | m_axis_tready;
  assign take          = in_valid & out_free;
  assign s_axis_tready = rst_ni & (~in_valid | out_free);
  assign in_accept     = s_axis_tvalid & s_axis_tready;
  assign cfg_ready_o   = rst_ni;

  assign item_in.mode       = s_axis_tuser;
  assign item_in.event_data = s_axis_tdata[lsmc_pkg::DataW-1:0];

  lsmc_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (in_accept),
    .take_i  (take),
    .item_i  (item_in),
    .valid_o (in_valid),
    .item_o  (item_q)
  );

  lsmc_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (take),
    .item_i      (item_q),
    .cfg_we_i    (cfg_valid_i & cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .result_o    (result_d)
  );

  lsmc_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (take),
    .ready_i  (m_axis_tready),
    .result_i (result_d),
    .valid_o  (m_axis_tvalid),
    .result_o (result_q)
  );

  // Pack result, padded to whole bytes
  assign m_axis_tdata = {5'b00000, result_q};

endmodule

// File: src/lsmc_checker.sv
// ----------------------------------------------------------------------------
// lsmc_checker: port-level checks of the light servo mode controller
// Watches the result stream for consistency of the status fields.
// ----------------------------------------------------------------------------
module lsmc_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic [lsmc_pkg::OutDataW-1:0]  m_axis_tdata
);

  // Stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Display follows power and mode
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[0] ? (m_axis_tdata[4:3] == m_axis_tdata[2:1])
                                        : (m_axis_tdata[4:3] == lsmc_pkg::DigitBlank)))
    else $error("digit_shown inconsistent with power and mode");

  // Potentiometer channel only in manual mode
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[5] == (m_axis_tdata[2:1] == lsmc_pkg::ModeManual)))
    else $error("channel_select inconsistent with mode");

  // Report value only with a light report
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[24:22] != lsmc_pkg::MsgReport)
      |-> (m_axis_tdata[34:25] == '0))
    else $error("report_value set without light report");

endmodule

bind light_servo_mode_controller lsmc_checker u_lsmc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the light servo mode controller
// Drives power, mode, character, tick, sample and unknown events on s_axis,
// predicts the status word for every accepted event and checks each m_axis
// transfer field by field. Both sides idle at random in some phases.
// Register writes happen only while the block is drained.
// ----------------------------------------------------------------------------
module tb;
  import lsmc_pkg::*;

  localparam int unsigned MaxGap     = 12;
  localparam int unsigned ErrShow    = 10;
  localparam int unsigned DrainLimit = 2000;
  localparam int unsigned PhaseItems = 80;

  localparam logic [CfgIdxW-1:0] CfgSpare   = 2'd3;
  localparam logic [EvW-1:0]     EvSpareLo  = 3'd5;
  localparam logic [EvW-1:0]     EvSpareHi  = 3'd7;
  localparam logic [7:0]         CharOne    = CharZero + 8'd1;
  localparam logic [7:0]         CharBelow  = CharZero - 8'd1;
  localparam logic [7:0]         CharAbove  = CharTwo + 8'd1;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [InDataW-1:0]    s_axis_tdata;
  logic [EvW-1:0]        s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OutDataW-1:0]   m_axis_tdata;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CfgIdxW-1:0]    cfg_index_i;
  logic [CfgDataW-1:0]   cfg_data_i;

  // Predicted block state and registers
  logic               pwr_q;
  logic [ModeW-1:0]   mode_q;
  logic [TickW-1:0]   ticks_q;
  logic [ServoW-1:0]  servo_q;
  logic [TickW-1:0]   interval_q;
  logic [ServoW-1:0]  base_q;

  result_t     status_q[$];
  int unsigned mismatch_cnt;
  bit          tx_idle;
  bit          rx_idle;

  light_servo_mode_controller u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Apply one event to the predicted state and return the status it yields
  function automatic result_t next_status(input logic [EvW-1:0] ev,
                                          input logic [DataW-1:0] dat);
    result_t     r;
    logic [7:0]  ch;
    int unsigned s;
    r  = '0;
    ch = dat[7:0];
    s  = dat >> 2;
    case (ev)
      EvPower: pwr_q = ~pwr_q;
      EvModeBtn: begin
        if (pwr_q) begin
          mode_q    = (mode_q >= ModeManual) ? ModeData : mode_q + 1'b1;
          r.message = MsgModeSet + mode_q;
        end
      end
      EvChar: begin
        if (pwr_q) begin
          if (ch >= CharZero && ch <= CharTwo) begin
            mode_q    = ModeW'(ch - CharZero);
            r.message = MsgModeSet + mode_q;
          end else begin
            r.message = MsgInvalid;
          end
        end
      end
      EvTick: ticks_q = ticks_q + 1'b1;
      EvSample: begin
        if (pwr_q) begin
          if (mode_q == ModeData) begin
            if (ticks_q > interval_q) begin
              r.message      = MsgReport;
              r.report_value = dat;
              ticks_q        = '0;
            end
          end else begin
            servo_q = ServoW'(base_q + 15 * s + 5 * (s >> 3));
          end
        end
      end
      default: ;
    endcase
    r.powered        = pwr_q;
    r.current_mode   = mode_q;
    r.digit_shown    = pwr_q ? mode_q : DigitBlank;
    r.channel_select = (mode_q == ModeManual);
    r.servo_compare  = servo_q;
    return r;
  endfunction

  function automatic void note_error(input string what, input int unsigned want,
                                     input int unsigned got);
    mismatch_cnt++;
    if (mismatch_cnt <= ErrShow)
      $display("mismatch %s: expected %0d, got %0d", what, want, got);
  endfunction

  function automatic void check_field(input string what, input int unsigned want,
                                      input int unsigned got);
    if (want != got) note_error(what, want, got);
  endfunction

  // Compare every status transfer with the oldest prediction
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = result_t'(m_axis_tdata[$bits(result_t)-1:0]);
      if (status_q.size() == 0) begin
        note_error("unexpected status transfer", 0, 1);
      end else begin
        want = status_q.pop_front();
        check_field("powered", want.powered, got.powered);
        check_field("current_mode", want.current_mode, got.current_mode);
        check_field("digit_shown", want.digit_shown, got.digit_shown);
        check_field("channel_select", want.channel_select, got.channel_select);
        check_field("servo_compare", want.servo_compare, got.servo_compare);
        check_field("message", want.message, got.message);
        check_field("report_value", want.report_value, got.report_value);
      end
    end
  end

  // Status receiver: if rx_idle, hold off a random number of cycles per transfer
  initial begin
    int unsigned n;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      n = rx_idle ? $urandom_range(0, MaxGap) : 0;
      @(negedge clk_i);
      if (n > 0) begin
        m_axis_tready <= 1'b0;
        repeat (n) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // Send one event, record its prediction when the transfer happens
  task automatic send_event(input logic [EvW-1:0] ev, input logic [DataW-1:0] dat);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, MaxGap) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= ev;
    s_axis_tdata  <= InDataW'(dat);
    do @(posedge clk_i); while (!s_axis_tready);
    status_q.push_back(next_status(ev, dat));
  endtask

  // Drop valid, wait for every predicted status or the drain limit
  task automatic wait_idle();
    int unsigned n;
    n = 0;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (status_q.size() != 0 && n < DrainLimit) begin
      @(posedge clk_i);
      n++;
    end
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx,
                           input logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgReportInterval: interval_q = val[TickW-1:0];
      CfgServoBase:      base_q     = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Weighted random event, mostly powered traffic with real samples and ticks
  task automatic send_random_event();
    int unsigned      pick;
    logic [EvW-1:0]   ev;
    logic [DataW-1:0] dat;
    pick = $urandom_range(0, 99);
    dat  = DataW'($urandom);
    if (!pwr_q && $urandom_range(0, 2) == 0) ev = EvPower;
    else if (pick < 3)  ev = EvPower;
    else if (pick < 10) ev = EvModeBtn;
    else if (pick < 22) begin
      ev = EvChar;
      if (pick < 17) dat[7:0] = CharZero + 8'($urandom_range(0, 2));
    end
    else if (pick < 55) ev = EvTick;
    else if (pick < 96) ev = EvSample;
    else ev = EvW'($urandom_range(EvSpareLo, EvSpareHi));
    send_event(ev, dat);
  endtask

  // Buttons, characters, unknown codes and sample extremes, powered and not
  task automatic test_buttons_and_chars();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    send_event(EvModeBtn, '0);
    send_event(EvChar, DataW'(CharOne));
    send_event(EvSample, 10'h3FF);
    send_event(EvSpareLo, 10'h3FF);
    send_event(EvW'(EvSpareLo + 1'b1), '0);
    send_event(EvSpareHi, 10'h2AA);
    send_event(EvPower, '0);
    send_event(EvModeBtn, 10'h3FF);
    send_event(EvSample, '0);
    send_event(EvSample, 10'h3FF);
    send_event(EvModeBtn, '0);
    send_event(EvSample, 10'h155);
    send_event(EvModeBtn, '0);
    send_event(EvChar, {2'b11, CharTwo});
    send_event(EvChar, DataW'(CharBelow));
    send_event(EvChar, DataW'(CharAbove));
    send_event(EvChar, 10'h000);
    send_event(EvChar, 10'h0FF);
    send_event(EvChar, DataW'(CharOne));
    send_event(EvChar, DataW'(CharZero));
    send_event(EvSample, 10'h3FF);
    send_event(EvTick, 10'h3FF);
    send_event(EvPower, '0);
    send_event(EvTick, '0);
    send_event(EvPower, '0);
    wait_idle();
  endtask

  // Report right after the interval is passed, then let the tick count wrap
  task automatic test_tick_wrap();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    write_reg(CfgReportInterval, '0);
    write_reg(CfgSpare, CfgDataW'($urandom));
    if (!pwr_q) send_event(EvPower, '0);
    send_event(EvChar, DataW'(CharZero));
    send_event(EvTick, '0);
    send_event(EvSample, 10'h3FF);
    repeat (256) send_event(EvTick, DataW'($urandom));
    send_event(EvSample, 10'h2A5);
    send_event(EvTick, '0);
    send_event(EvSample, '0);
    wait_idle();
  endtask

  // One random phase at a given register setting and idling mix
  task automatic test_random_phase(input logic [CfgDataW-1:0] interval,
                                   input logic [CfgDataW-1:0] base,
                                   input bit tx_gaps, input bit rx_gaps);
    write_reg(CfgReportInterval, interval);
    write_reg(CfgServoBase, base);
    tx_idle = tx_gaps;
    rx_idle = rx_gaps;
    repeat (PhaseItems) send_random_event();
    wait_idle();
  endtask

  initial begin
    int unsigned i;
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    tx_idle       = 1'b0;
    rx_idle       = 1'b0;
    mismatch_cnt  = 0;
    pwr_q         = 1'b0;
    mode_q        = ModeData;
    ticks_q       = '0;
    servo_q       = ServoValueRst;
    interval_q    = ReportIntervalRst;
    base_q        = ServoBaseRst;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_buttons_and_chars();
    test_tick_wrap();
    test_random_phase(CfgDataW'(ReportIntervalRst), ServoBaseRst, 1'b1, 1'b1);
    test_random_phase('0, '0, 1'b0, 1'b0);
    test_random_phase(16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
    test_random_phase({8'($urandom), 8'($urandom_range(0, 40))}, 16'($urandom),
                      1'b0, 1'b1);
    test_random_phase(16'hFF00 | 16'($urandom_range(0, 30)), 16'($urandom),
                      1'b1, 1'b1);

    // Give stray transfers time to show up, then count what never arrived
    repeat (8) @(posedge clk_i);
    for (i = 0; i < status_q.size(); i++) note_error("missing status transfer", 1, 0);

    if (mismatch_cnt == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  // Hard stop if a handshake hangs
  initial begin
    #1000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
